/* hdl/cpv_pkg.sv */
package cpv_pkg;

	localparam int GAIN_W  = 16;
	localparam int OP_W    = 23;
	localparam int ACC_W   = OP_W + 2 + GAIN_W;
	localparam int CNT_W   = $clog2(GAIN_W + 1);
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;
	localparam int CLAMP_W = 30;

	localparam int OUTER_SHIFT = 11;
	localparam int INNER_SHIFT = 12;

	localparam int DRIVE_LIMIT_DEF    = 30000;
	localparam int VEL_DERIV_GAIN_DEF = 0;

	localparam logic [15:0] POS_KP_RST   = 16'd2560;
	localparam logic [15:0] POS_KI_RST   = 16'd26;
	localparam logic [15:0] POS_KD_RST   = 16'd0;
	localparam logic [15:0] POS_ILIM_RST = 16'd12800;
	localparam logic [14:0] POS_OLIM_RST = 15'd4800;
	localparam logic [15:0] VEL_KP_RST   = 16'd20480;
	localparam logic [15:0] VEL_KI_RST   = 16'd0;
	localparam logic [19:0] VEL_ILIM_RST = 20'd0;

	typedef enum logic [IDX_W-1:0] {
		REG_POS_KP   = 3'd0,
		REG_POS_KI   = 3'd1,
		REG_POS_KD   = 3'd2,
		REG_POS_ILIM = 3'd3,
		REG_POS_OLIM = 3'd4,
		REG_VEL_KP   = 3'd5,
		REG_VEL_KI   = 3'd6,
		REG_VEL_ILIM = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pos_kp;
		logic [15:0] pos_ki;
		logic [15:0] pos_kd;
		logic [15:0] pos_ilim;
		logic [14:0] pos_olim;
		logic [15:0] vel_kp;
		logic [15:0] vel_ki;
		logic [19:0] vel_ilim;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPREP,
		ST_OMAC,
		ST_OFIN,
		ST_IPREP,
		ST_IMAC,
		ST_IFIN
	} state_t;

	typedef struct packed {
		logic                     start;
		logic signed [OP_W-1:0]   op_a;
		logic signed [OP_W-1:0]   op_b;
		logic signed [OP_W-1:0]   op_c;
		logic        [GAIN_W-1:0] gain_a;
		logic        [GAIN_W-1:0] gain_b;
		logic        [GAIN_W-1:0] gain_c;
	} mac_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

/* hdl/cpv_if.sv */
interface cpv_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target_position;
	logic signed [15:0] measured_position;
	logic signed [15:0] measured_velocity;

	modport source (
		output valid, target_position, measured_position, measured_velocity,
		input  ready
	);
	modport sink (
		input  valid, target_position, measured_position, measured_velocity,
		output ready
	);
endinterface

interface cpv_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;
	logic signed [15:0] velocity_reference;

	modport source (
		output valid, drive, velocity_reference,
		input  ready
	);
	modport sink (
		input  valid, drive, velocity_reference,
		output ready
	);
endinterface

/* hdl/cpv_cfg.sv */
module cpv_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cpv_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cpv_pkg::CFG_W-1:0]   cfg_data,
	output cpv_pkg::cfg_t               cfg
);

	cpv_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_kp   <= cpv_pkg::POS_KP_RST;
			cfg_q.pos_ki   <= cpv_pkg::POS_KI_RST;
			cfg_q.pos_kd   <= cpv_pkg::POS_KD_RST;
			cfg_q.pos_ilim <= cpv_pkg::POS_ILIM_RST;
			cfg_q.pos_olim <= cpv_pkg::POS_OLIM_RST;
			cfg_q.vel_kp   <= cpv_pkg::VEL_KP_RST;
			cfg_q.vel_ki   <= cpv_pkg::VEL_KI_RST;
			cfg_q.vel_ilim <= cpv_pkg::VEL_ILIM_RST;
		end else if (cfg_we) begin
			unique case (cpv_pkg::reg_idx_t'(cfg_index))
				cpv_pkg::REG_POS_KP:   cfg_q.pos_kp   <= cfg_data[15:0];
				cpv_pkg::REG_POS_KI:   cfg_q.pos_ki   <= cfg_data[15:0];
				cpv_pkg::REG_POS_KD:   cfg_q.pos_kd   <= cfg_data[15:0];
				cpv_pkg::REG_POS_ILIM: cfg_q.pos_ilim <= cfg_data[15:0];
				cpv_pkg::REG_POS_OLIM: cfg_q.pos_olim <= cfg_data[14:0];
				cpv_pkg::REG_VEL_KP:   cfg_q.vel_kp   <= cfg_data[15:0];
				cpv_pkg::REG_VEL_KI:   cfg_q.vel_ki   <= cfg_data[15:0];
				cpv_pkg::REG_VEL_ILIM: cfg_q.vel_ilim <= cfg_data[19:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/cpv_mac.sv */
module cpv_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cpv_pkg::mac_req_t                    req,
	output cpv_pkg::mac_stat_t                   stat,
	output logic signed [cpv_pkg::ACC_W-1:0]     acc
);

	localparam int XW = cpv_pkg::OP_W + 3;
	localparam int HW = cpv_pkg::OP_W + 2;

	logic [cpv_pkg::GAIN_W-1:0]        ga_q, gb_q, gc_q;
	logic signed [cpv_pkg::OP_W-1:0]   a_q, b_q, c_q;
	logic signed [HW-1:0]              hi_q;
	logic [cpv_pkg::GAIN_W-1:0]        lo_q;
	logic [cpv_pkg::CNT_W-1:0]         cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic signed [XW-1:0] term;
	logic signed [XW-1:0] sum;

	// one gain bit of all three products per cycle, added at the top of a right-shifting sum
	always_comb begin
		term = (ga_q[0] ? XW'(a_q) : '0)
		     + (gb_q[0] ? XW'(b_q) : '0)
		     + (gc_q[0] ? XW'(c_q) : '0);
		sum  = XW'(hi_q) + term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cpv_pkg::CNT_W'(cpv_pkg::GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cpv_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ga_q <= req.gain_a;
			gb_q <= req.gain_b;
			gc_q <= req.gain_c;
			a_q  <= req.op_a;
			b_q  <= req.op_b;
			c_q  <= req.op_c;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			ga_q <= ga_q >> 1;
			gb_q <= gb_q >> 1;
			gc_q <= gc_q >> 1;
			hi_q <= sum[XW-1:1];
			lo_q <= {sum[0], lo_q[cpv_pkg::GAIN_W-1:1]};
		end
	end

	assign acc       = $signed({hi_q, lo_q});
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hdl/cascaded_position_velocity_pid_unit.sv */
// One tick is worked on at a time: a new tick is accepted only once the last result is in
// the output register. Each tick takes two 16-step passes of the shared bit-serial
// multiply-accumulate unit (one gain bit per cycle, all three terms at once).
// The output register holds a result while the next tick is accepted and worked on.
// Reset clears the error sums, previous errors and output valid, and loads the
// register defaults into the configuration registers.
module cascaded_position_velocity_pid_unit #(
	parameter int DRIVE_LIMIT    = cpv_pkg::DRIVE_LIMIT_DEF,
	parameter int VEL_DERIV_GAIN = cpv_pkg::VEL_DERIV_GAIN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cpv_tick_if.sink                    tick,
	cpv_result_if.source                result,
	input  logic                        cfg_we,
	input  logic [cpv_pkg::IDX_W-1:0]   cfg_index,
	input  logic [cpv_pkg::CFG_W-1:0]   cfg_data
);

	localparam int CW = cpv_pkg::CLAMP_W;
	localparam logic [15:0]        DRV_LIM   = 16'(DRIVE_LIMIT);
	localparam logic signed [16:0] DRV_LIM_S = 17'(DRIVE_LIMIT);
	localparam logic [15:0]        VEL_KD    = 16'(VEL_DERIV_GAIN);

	function automatic logic signed [CW-1:0] clamp_sym(input logic signed [CW-1:0] x,
		input logic [19:0] lim);
		logic signed [CW-1:0] l;
		l = $signed(CW'(lim));
		if (x >= l)
			return l;
		else if (x <= -l)
			return -l;
		else
			return x;
	endfunction

	cpv_pkg::cfg_t      cfg;
	cpv_pkg::mac_req_t  mac_req;
	cpv_pkg::mac_stat_t mac_stat;
	logic signed [cpv_pkg::ACC_W-1:0] mac_acc;

	cpv_pkg::state_t state_q, state_d;

	logic signed [15:0] tp_q, mp_q, mv_q;
	logic signed [17:0] psum_q;
	logic signed [16:0] ppe_q;
	logic signed [20:0] vsum_q;
	logic signed [16:0] pve_q;
	logic signed [15:0] vref_q;
	logic signed [15:0] drive_q, vref_out_q;
	logic               res_valid_q;

	logic signed [16:0] pe, ve;
	logic signed [18:0] psum_raw;
	logic signed [21:0] vsum_raw;
	logic signed [17:0] psum_new;
	logic signed [20:0] vsum_new;
	logic signed [17:0] pde, vde;
	logic signed [15:0] vref_new, drive_new;
	logic               out_free;
	logic               load_out;

	cpv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.stat   (mac_stat),
		.acc    (mac_acc)
	);

	always_comb begin
		pe       = 17'(tp_q) - 17'(mp_q);
		psum_raw = 19'(psum_q) + 19'(pe);
		psum_new = 18'(clamp_sym(CW'(psum_raw), 20'(cfg.pos_ilim)));
		pde      = 18'(pe) - 18'(ppe_q);
		vref_new = 16'(clamp_sym($signed(mac_acc[cpv_pkg::ACC_W-1:cpv_pkg::OUTER_SHIFT]),
			20'(cfg.pos_olim)));

		ve       = 17'(vref_q) - 17'(mv_q);
		vsum_raw = 22'(vsum_q) + 22'(ve);
		vsum_new = 21'(clamp_sym(CW'(vsum_raw), cfg.vel_ilim));
		vde      = 18'(ve) - 18'(pve_q);
		drive_new = 16'(clamp_sym(
			CW'($signed(mac_acc[cpv_pkg::ACC_W-1:cpv_pkg::INNER_SHIFT])), 20'(DRV_LIM)));
	end

	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpv_pkg::ST_IDLE:  if (tick.valid) state_d = cpv_pkg::ST_OPREP;
			cpv_pkg::ST_OPREP: state_d = cpv_pkg::ST_OMAC;
			cpv_pkg::ST_OMAC:  if (mac_stat.done) state_d = cpv_pkg::ST_OFIN;
			cpv_pkg::ST_OFIN:  state_d = cpv_pkg::ST_IPREP;
			cpv_pkg::ST_IPREP: state_d = cpv_pkg::ST_IMAC;
			cpv_pkg::ST_IMAC:  if (mac_stat.done) state_d = cpv_pkg::ST_IFIN;
			cpv_pkg::ST_IFIN:  if (out_free) state_d = cpv_pkg::ST_IDLE;
			default:           state_d = cpv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tick.ready     = (state_q == cpv_pkg::ST_IDLE);
		load_out       = (state_q == cpv_pkg::ST_IFIN) && out_free;
		mac_req.start  = (state_q == cpv_pkg::ST_OPREP) || (state_q == cpv_pkg::ST_IPREP);
		if (state_q == cpv_pkg::ST_OPREP) begin
			mac_req.op_a   = cpv_pkg::OP_W'(pe);
			mac_req.op_b   = cpv_pkg::OP_W'(psum_new);
			mac_req.op_c   = cpv_pkg::OP_W'(pde);
			mac_req.gain_a = cfg.pos_kp;
			mac_req.gain_b = cfg.pos_ki;
			mac_req.gain_c = cfg.pos_kd;
		end else begin
			mac_req.op_a   = cpv_pkg::OP_W'(ve);
			mac_req.op_b   = cpv_pkg::OP_W'(vsum_new);
			mac_req.op_c   = cpv_pkg::OP_W'(vde);
			mac_req.gain_a = cfg.vel_kp;
			mac_req.gain_b = cfg.vel_ki;
			mac_req.gain_c = VEL_KD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpv_pkg::ST_IDLE;
			psum_q      <= '0;
			ppe_q       <= '0;
			vsum_q      <= '0;
			pve_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cpv_pkg::ST_OPREP) begin
				psum_q <= psum_new;
				ppe_q  <= pe;
			end
			if (state_q == cpv_pkg::ST_IPREP) begin
				vsum_q <= vsum_new;
				pve_q  <= ve;
			end
			if (load_out)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tp_q <= tick.target_position;
			mp_q <= tick.measured_position;
			mv_q <= tick.measured_velocity;
		end
		if (state_q == cpv_pkg::ST_OFIN)
			vref_q <= vref_new;
		if (load_out) begin
			drive_q    <= drive_new;
			vref_out_q <= vref_q;
		end
	end

	assign result.valid              = res_valid_q;
	assign result.drive              = drive_q;
	assign result.velocity_reference = vref_out_q;

	a_mac_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_req.start |-> !mac_stat.busy)
		else $error("multiply-accumulate started while busy");

	a_mac_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> (state_q == cpv_pkg::ST_OMAC || state_q == cpv_pkg::ST_IMAC))
		else $error("multiply-accumulate finished outside a wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> (state_q == cpv_pkg::ST_OPREP))
		else $error("accepted tick did not start the outer loop");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (17'(result.drive) <= DRV_LIM_S && 17'(result.drive) >= -DRV_LIM_S))
		else $error("drive outside its limit");

endmodule
